@@ src/tll_pkg.sv @@
`default_nettype none

package tll_pkg;

    // Token kinds as reported on the result channel
    localparam logic [4:0] K_TYPE    = 5'd0;
    localparam logic [4:0] K_INT     = 5'd1;
    localparam logic [4:0] K_KEYWORD = 5'd2;
    localparam logic [4:0] K_SEP     = 5'd3;
    localparam logic [4:0] K_ASSIGN  = 5'd4;
    localparam logic [4:0] K_ADD     = 5'd5;
    localparam logic [4:0] K_SUB     = 5'd6;
    localparam logic [4:0] K_MUL     = 5'd7;
    localparam logic [4:0] K_DIV     = 5'd8;
    localparam logic [4:0] K_INC     = 5'd9;
    localparam logic [4:0] K_DEC     = 5'd10;
    localparam logic [4:0] K_EXP     = 5'd11;
    localparam logic [4:0] K_INTDIV  = 5'd12;
    localparam logic [4:0] K_MOD     = 5'd13;
    localparam logic [4:0] K_OPER    = 5'd14;
    localparam logic [4:0] K_IDENT   = 5'd15;
    localparam logic [4:0] K_END     = 5'd16;

    // Bytes the scanner reacts to
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;

    // Word prefix holds up to seven bytes, first byte in the low octet
    localparam int unsigned PREFIX_BYTES = 7;

    // Reserved words, packed first byte lowest and zero padded
    localparam logic [55:0] KW_PRINT   = 56'h0000746E697270; // print
    localparam logic [55:0] KW_RETURN  = 56'h006E7275746572; // return
    localparam logic [55:0] KW_EXIT    = 56'h00000074697865; // exit
    localparam logic [55:0] KW_ANOTHER = 56'h726568746F6E61; // another
    localparam logic [55:0] KW_IF      = 56'h00000000006669; // if
    localparam logic [55:0] KW_INTW    = 56'h00000000746E69; // int
    localparam logic [55:0] KW_FLOAT   = 56'h000074616F6C66; // float

    localparam logic [2:0] KL_PRINT   = 3'd5;
    localparam logic [2:0] KL_RETURN  = 3'd6;
    localparam logic [2:0] KL_EXIT    = 3'd4;
    localparam logic [2:0] KL_ANOTHER = 3'd7;
    localparam logic [2:0] KL_IF      = 3'd2;
    localparam logic [2:0] KL_INTW    = 3'd3;
    localparam logic [2:0] KL_FLOAT   = 3'd5;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic        last;
    } t_token;

endpackage

`default_nettype wire

@@ src/tll_scan.sv @@
`default_nettype none

module tll_scan
    import tll_pkg::*;
#(
    parameter int LENGTH_BITS   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_take,
    input  wire   [7:0]  i_byte,
    output logic  [1:0]  o_count,
    output t_token       o_tok0,
    output t_token       o_tok1
);

    typedef enum logic [3:0] {
        M_IDLE, M_INT, M_WORD, M_EQ, M_PCT, M_PLUS, M_MINUS, M_STAR, M_SLASH
    } t_mode;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    t_mode                     r_mode, n_mode;
    logic [LENGTH_BITS-1:0]    r_len, n_len;
    logic [POSITION_BITS-1:0]  r_start, n_start;
    logic [POSITION_BITS-1:0]  r_pos, n_pos;
    logic [55:0]               r_prefix, n_prefix;

    logic        is_digit, is_alpha, cont, flush, emit_new;
    logic        len1, len2;
    logic [4:0]  pend_kind, new_kind;
    t_mode       start_mode;
    t_token      flush_tok, new_tok;

    function automatic logic word_is(input logic [55:0] pfx, input logic [LENGTH_BITS-1:0] len,
                                     input logic [55:0] kw, input logic [2:0] kl);
        return (len == LENGTH_BITS'(kl)) && (pfx == kw);
    endfunction

    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_alpha = ((i_byte >= 8'h41) && (i_byte <= 8'h5A)) ||
                      ((i_byte >= 8'h61) && (i_byte <= 8'h7A));
    assign len1 = (r_len == LENGTH_BITS'(1));
    assign len2 = (r_len == LENGTH_BITS'(2));

    always_comb begin
        case (r_mode)
            M_INT:   cont = is_digit;
            M_WORD:  cont = (i_byte != CH_SPACE) && (i_byte != CH_NUL) &&
                            (i_byte != CH_LPAR) && (i_byte != CH_RPAR);
            M_EQ,
            M_PCT:   cont = !is_digit && !is_alpha && (i_byte != CH_SPACE) &&
                            (i_byte != CH_NUL);
            M_PLUS:  cont = (i_byte == CH_PLUS)  || (i_byte == CH_EQ);
            M_MINUS: cont = (i_byte == CH_MINUS) || (i_byte == CH_EQ);
            M_STAR:  cont = (i_byte == CH_STAR)  || (i_byte == CH_EQ);
            M_SLASH: cont = (i_byte == CH_SLASH) || (i_byte == CH_EQ);
            default: cont = 1'b0;
        endcase
    end

    // Classify the token in progress
    always_comb begin
        case (r_mode)
            M_INT:   pend_kind = K_INT;
            M_WORD: begin
                if (word_is(r_prefix, r_len, KW_PRINT, KL_PRINT) ||
                    word_is(r_prefix, r_len, KW_RETURN, KL_RETURN) ||
                    word_is(r_prefix, r_len, KW_EXIT, KL_EXIT) ||
                    word_is(r_prefix, r_len, KW_ANOTHER, KL_ANOTHER) ||
                    word_is(r_prefix, r_len, KW_IF, KL_IF))
                    pend_kind = K_KEYWORD;
                else if (word_is(r_prefix, r_len, KW_INTW, KL_INTW) ||
                         word_is(r_prefix, r_len, KW_FLOAT, KL_FLOAT))
                    pend_kind = K_TYPE;
                else
                    pend_kind = K_IDENT;
            end
            M_EQ:    pend_kind = len1 ? K_ASSIGN : K_OPER;
            M_PCT:   pend_kind = len1 ? K_MOD : K_OPER;
            M_PLUS:  pend_kind = len1 ? K_ADD : (len2 ? K_INC : K_OPER);
            M_MINUS: pend_kind = len1 ? K_SUB : (len2 ? K_DEC : K_OPER);
            M_STAR:  pend_kind = len1 ? K_MUL : (len2 ? K_EXP : K_OPER);
            M_SLASH: pend_kind = len1 ? K_DIV : (len2 ? K_INTDIV : K_OPER);
            default: pend_kind = K_OPER;
        endcase
    end

    // Decide what a fresh byte starts
    always_comb begin
        start_mode = M_IDLE;
        emit_new   = 1'b0;
        new_kind   = K_SEP;
        if (i_byte == CH_NUL) begin
            emit_new = 1'b1;
            new_kind = K_END;
        end else if (is_digit) begin
            start_mode = M_INT;
        end else if (is_alpha) begin
            start_mode = M_WORD;
        end else if ((i_byte == CH_SEMI) || (i_byte == CH_LPAR) || (i_byte == CH_RPAR)) begin
            emit_new = 1'b1;
        end else if (i_byte == CH_EQ) begin
            start_mode = M_EQ;
        end else if (i_byte == CH_PCT) begin
            start_mode = M_PCT;
        end else if (i_byte == CH_PLUS) begin
            start_mode = M_PLUS;
        end else if (i_byte == CH_MINUS) begin
            start_mode = M_MINUS;
        end else if (i_byte == CH_STAR) begin
            start_mode = M_STAR;
        end else if (i_byte == CH_SLASH) begin
            start_mode = M_SLASH;
        end
    end

    assign flush = (r_mode != M_IDLE) && !cont;

    always_comb begin
        flush_tok.kind   = pend_kind;
        flush_tok.start  = 32'(64'(r_start));
        flush_tok.length = (32'(r_len) > 32'd65535) ? 16'hFFFF : 16'(r_len);
        flush_tok.last   = !emit_new;
        new_tok.kind     = new_kind;
        new_tok.start    = 32'(64'(r_pos));
        new_tok.length   = (new_kind == K_END) ? 16'd2 : 16'd1;
        new_tok.last     = 1'b1;
    end

    always_comb begin
        if ((r_mode != M_IDLE) && cont) begin
            o_count = 2'd0;
        end else begin
            o_count = {1'b0, flush} + {1'b0, emit_new};
        end
        o_tok0 = flush ? flush_tok : new_tok;
        o_tok1 = new_tok;
    end

    // Next state
    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_start  = r_start;
        n_pos    = r_pos;
        n_prefix = r_prefix;
        if ((r_mode != M_IDLE) && cont) begin
            if (32'(r_len) < PREFIX_BYTES)
                n_prefix[8*r_len[2:0] +: 8] = i_byte;
            if (r_len != LEN_MAX)
                n_len = r_len + LENGTH_BITS'(1);
            n_pos = r_pos + POSITION_BITS'(1);
        end else if (i_byte == CH_NUL) begin
            n_mode   = M_IDLE;
            n_len    = '0;
            n_start  = '0;
            n_pos    = '0;
            n_prefix = '0;
        end else begin
            n_mode   = start_mode;
            n_start  = (start_mode != M_IDLE) ? r_pos : r_start;
            n_len    = (start_mode != M_IDLE) ? LENGTH_BITS'(1) : '0;
            n_prefix = (start_mode != M_IDLE) ? {48'd0, i_byte} : 56'd0;
            n_pos    = r_pos + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_len    <= '0;
            r_start  <= '0;
            r_pos    <= '0;
            r_prefix <= '0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_len    <= n_len;
            r_start  <= n_start;
            r_pos    <= n_pos;
            r_prefix <= n_prefix;
        end
    end

endmodule

`default_nettype wire

@@ src/tll_outq.sv @@
`default_nettype none

module tll_outq
    import tll_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire   [1:0]  i_count,
    input  t_token       i_tok0,
    input  t_token       i_tok1,
    output logic         o_full,
    output logic         o_valid,
    input  wire          i_stall,
    output t_token       o_tok
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_token           r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             pop;
    logic [AW-1:0]    wp1;

    assign wp1     = r_wp + AW'(1);
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    // Hold the producer unless room for two items remains
    assign o_full  = (r_cnt > (AW+1)'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0)
            r_mem[r_wp] <= i_tok0;
        if (i_count == 2'd2)
            r_mem[wp1] <= i_tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(i_count);
            r_rp  <= r_rp + AW'(pop);
            r_cnt <= r_cnt + (AW+1)'(i_count) - (AW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

@@ src/toy_language_lexer.sv @@
`default_nettype none

// Streaming lexer for a small toy language.
// Input channel: one source byte per item on i_text_byte, taken when i_valid
// is high and o_stall is low. A zero byte ends the text.
// Output channel: one token per item (kind, start offset, length and a flag
// marking the last token caused by a given byte), taken when o_valid is high
// and i_stall is low.
// Each byte is scanned in the cycle it is taken; any tokens it finishes are
// written into a four-entry result queue and can be shown from the next
// cycle. One byte can be taken every cycle while o_stall is low; a byte
// that finishes a token and is itself a separator or the end of text
// produces two tokens, which drain at one per cycle while i_stall is low.
// o_stall rises while fewer than two queue entries are free, so a receiver
// that stalls backs the sender up and nothing is lost; a stalled token
// holds its value until taken.
// Synchronous reset clears the scanner to idle at offset zero and empties
// the queue. The end-of-text byte does the same to the scanner, so the next
// text starts at offset zero.
module toy_language_lexer
    import tll_pkg::*;
#(
    parameter int LENGTH_BITS   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire   [7:0]  i_text_byte,
    output logic         o_valid,
    input  wire          i_stall,
    output logic  [4:0]  o_token_kind,
    output logic  [31:0] o_token_start,
    output logic  [15:0] o_token_length,
    output logic         o_last_of_run
);

    logic        take;
    logic [1:0]  scan_count;
    logic [1:0]  push_count;
    logic        q_full;
    t_token      tok0, tok1, head;

    // Take a byte only when the queue can absorb its worst case of two tokens
    assign o_stall    = q_full;
    assign take       = i_valid && !q_full;
    assign push_count = take ? scan_count : 2'd0;

    tll_scan #(
        .LENGTH_BITS   (LENGTH_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_text_byte),
        .o_count (scan_count),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    tll_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (push_count),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_tok   (head)
    );

    // Unpack the head of the queue onto the result ports
    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_last_of_run  = head.last;

endmodule

`default_nettype wire
